// ===== hw/rtl/io_latency_histogram_top_defines.svh =====
// assertion macros for the io latency histogram block
// included by the top level, needs nothing else
`ifndef IO_LATENCY_HISTOGRAM_TOP_DEFINES_SVH
`define IO_LATENCY_HISTOGRAM_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ILH_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ILH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ilh_pkg.sv =====
// types and constants of the io latency histogram block
// no dependencies
package ilh_pkg;

   localparam int unsigned FUNC_W = 2;
   localparam int unsigned DEV_W  = 32;
   localparam int unsigned TS_W   = 64;
   localparam int unsigned CNT_W  = 32;
   localparam int unsigned BKT_W  = 3;

   localparam int unsigned NUM_BUCKETS = 8;
   localparam int unsigned NUM_LIMITS  = NUM_BUCKETS - 1;
   localparam logic [BKT_W-1:0] LAST_BUCKET = BKT_W'(NUM_BUCKETS - 1);

   // upper bounds (exclusive) of buckets 0..6 in microseconds when NS_PER_UNIT is 1000
   localparam int unsigned BUCKET_LIMIT_US [NUM_LIMITS] = '{1, 5, 17, 65, 257, 1000, 4000};

   // function codes on the request channel
   localparam logic [FUNC_W-1:0] FUNC_ISSUE    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_COMPLETE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READOUT  = 2'd2;

   typedef enum logic [1:0] {
      OP_ISSUE,
      OP_COMPLETE,
      OP_READOUT
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [DEV_W-1:0]  device_id;
      logic [TS_W-1:0]   timestamp_ns;
   } cmd_type;

   typedef struct packed {
      logic              valid;
      logic [DEV_W-1:0]  device_id;
      logic [TS_W-1:0]   start_time;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic clearing;
      logic busy;
   } back_status_type;

endpackage

// ===== hw/rtl/ilh_req_if.sv =====
// request channel of the io latency histogram block
// uses ilh_pkg widths
interface ilh_req_if;
   logic                        valid;
   logic                        ready;
   logic [ilh_pkg::FUNC_W-1:0]  func;
   logic [ilh_pkg::DEV_W-1:0]   device_id;
   logic [ilh_pkg::TS_W-1:0]    timestamp_ns;

   modport source (output valid, func, device_id, timestamp_ns, input ready);
   modport sink   (input valid, func, device_id, timestamp_ns, output ready);
endinterface

// ===== hw/rtl/ilh_rsp_if.sv =====
// response channel of the io latency histogram block
// uses ilh_pkg widths
interface ilh_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ilh_pkg::BKT_W-1:0]   bucket_index;
   logic [ilh_pkg::CNT_W-1:0]   bucket_count;
   logic                        last;

   modport source (output valid, bucket_index, bucket_count, last, input ready);
   modport sink   (input valid, bucket_index, bucket_count, last, output ready);
endinterface

// ===== hw/rtl/ilh_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module ilh_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [AW-1:0]        rd_addr,
   output logic [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hw/rtl/ilh_front.sv =====
// front end: accepts request beats, decodes the function, holds one command
// uses ilh_pkg and ilh_req_if
module ilh_front (
   input  logic              clock,
   input  logic              reset,
   ilh_req_if.sink           req_ch,
   input  logic              hold_off,
   output logic              push,
   output ilh_pkg::cmd_type  push_data,
   input  logic              full
);
   logic             hold_valid_ff, hold_valid_in;
   ilh_pkg::cmd_type hold_cmd_ff, hold_cmd_in;
   logic             accept;
   logic             func_ok;
   ilh_pkg::op_type  dec_op;

   assign push         = hold_valid_ff && !full;
   assign push_data    = hold_cmd_ff;
   assign req_ch.ready = !hold_off && (!hold_valid_ff || !full);
   assign accept       = req_ch.valid && req_ch.ready;

   // unused function code is taken and dropped
   always_comb begin
      func_ok = 1'b1;
      dec_op  = ilh_pkg::OP_ISSUE;
      unique case (req_ch.func)
         ilh_pkg::FUNC_ISSUE:    dec_op = ilh_pkg::OP_ISSUE;
         ilh_pkg::FUNC_COMPLETE: dec_op = ilh_pkg::OP_COMPLETE;
         ilh_pkg::FUNC_READOUT:  dec_op = ilh_pkg::OP_READOUT;
         default:                func_ok = 1'b0;
      endcase
   end

   always_comb begin
      hold_cmd_in = hold_cmd_ff;
      if (accept) begin
         hold_valid_in            = func_ok;
         hold_cmd_in.op           = dec_op;
         hold_cmd_in.device_id    = req_ch.device_id;
         hold_cmd_in.timestamp_ns = req_ch.timestamp_ns;
      end else begin
         hold_valid_in = hold_valid_ff && !push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_cmd_ff <= hold_cmd_in;
   end
endmodule

// ===== hw/rtl/ilh_queue.sv =====
// small command fifo between front and back end
// uses ilh_pkg
module ilh_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ilh_pkg::cmd_type  push_data,
   output logic              full,
   input  logic              pop,
   output ilh_pkg::cmd_type  pop_data,
   output logic              empty
);
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   ilh_pkg::cmd_type   fifo_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ===== hw/rtl/ilh_back.sv =====
// back end: table clear sweep, table scan, latency bucketing, histogram counts and readout
// uses ilh_pkg, ilh_rsp_if and ilh_ram
module ilh_back #(
   parameter int unsigned TABLE_ENTRIES = 16,
   parameter int unsigned NS_PER_UNIT   = 1000
) (
   input  logic                      clock,
   input  logic                      reset,
   output logic                      pop,
   input  ilh_pkg::cmd_type          pop_data,
   input  logic                      empty,
   ilh_rsp_if.source                 rsp_ch,
   output ilh_pkg::back_status_type  status
);
   localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);
   localparam int unsigned BKT_W = ilh_pkg::BKT_W;
   localparam int unsigned CNT_W = ilh_pkg::CNT_W;
   localparam int unsigned TS_W  = ilh_pkg::TS_W;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_DECIDE = 3'd3;
   localparam logic [2:0] ST_BUCKET = 3'd4;
   localparam logic [2:0] ST_READ   = 3'd5;

   logic [2:0]          state_ff, state_in;
   ilh_pkg::cmd_type    cmd_ff, cmd_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                iss_done_ff, iss_done_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic                found_ff, found_in;
   logic [IDX_W-1:0]    match_idx_ff, match_idx_in;
   logic [TS_W-1:0]     match_time_ff, match_time_in;
   logic                free_ok_ff, free_ok_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic [TS_W-1:0]     diff_ff, diff_in;
   logic [CNT_W-1:0]    counts_ff [ilh_pkg::NUM_BUCKETS];
   logic [CNT_W-1:0]    counts_in [ilh_pkg::NUM_BUCKETS];
   logic [BKT_W-1:0]    rd_k_ff, rd_k_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BKT_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [CNT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   ilh_pkg::entry_type     wr_entry;
   logic [ilh_pkg::ENTRY_W-1:0] rd_data;
   ilh_pkg::entry_type     rd_entry;
   logic [ilh_pkg::NUM_LIMITS-1:0] at_least;
   logic [BKT_W-1:0]       bucket;
   logic                   out_free;

   ilh_ram #(
      .WIDTH (ilh_pkg::ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign rd_entry = ilh_pkg::entry_type'(rd_data);

   // latency class from compares of the raw difference against scaled limits
   for (genvar j = 0; j < ilh_pkg::NUM_LIMITS; j++) begin : g_limit
      localparam logic [TS_W-1:0] THRESH =
         TS_W'(64'(ilh_pkg::BUCKET_LIMIT_US[j]) * 64'(NS_PER_UNIT));
      assign at_least[j] = (diff_ff >= THRESH);
   end

   always_comb begin
      bucket = '0;
      for (int j = 0; j < ilh_pkg::NUM_LIMITS; j++) begin
         bucket = bucket + BKT_W'(at_least[j]);
      end
   end

   assign out_free        = !rsp_valid_ff || rsp_ch.ready;
   assign pop             = (state_ff == ST_IDLE) && !empty;
   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.busy     = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      rd_idx_in     = rd_idx_ff;
      iss_done_in   = iss_done_ff;
      rd_pend_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      found_in      = found_ff;
      match_idx_in  = match_idx_ff;
      match_time_in = match_time_ff;
      free_ok_in    = free_ok_ff;
      free_idx_in   = free_idx_ff;
      diff_in       = diff_ff;
      counts_in     = counts_ff;
      rd_k_in       = rd_k_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = rd_idx_ff;
      wr_entry      = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (rd_idx_ff == IDX_LAST) begin
               rd_idx_in = '0;
               state_in  = ST_IDLE;
            end else begin
               rd_idx_in = rd_idx_ff + IDX_W'(1);
            end
         end
         ST_IDLE: begin
            if (!empty) begin
               cmd_in      = pop_data;
               rd_idx_in   = '0;
               iss_done_in = 1'b0;
               found_in    = 1'b0;
               free_ok_in  = 1'b0;
               rd_k_in     = '0;
               state_in    = (pop_data.op == ilh_pkg::OP_READOUT) ? ST_READ : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue one table read a cycle, compare the entry returned
            if (!iss_done_ff) begin
               rd_pend_in = 1'b1;
               cmp_idx_in = rd_idx_ff;
               if (rd_idx_ff == IDX_LAST) begin
                  iss_done_in = 1'b1;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
               end
            end
            if (rd_pend_ff) begin
               if (rd_entry.valid && (rd_entry.device_id == cmd_ff.device_id)
                   && !found_ff) begin
                  found_in      = 1'b1;
                  match_idx_in  = cmp_idx_ff;
                  match_time_in = rd_entry.start_time;
               end
               if (!rd_entry.valid && !free_ok_ff) begin
                  free_ok_in  = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
               if (cmp_idx_ff == IDX_LAST) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
            if (cmd_ff.op == ilh_pkg::OP_ISSUE) begin
               wr_en               = found_ff || free_ok_ff;
               wr_addr             = found_ff ? match_idx_ff : free_idx_ff;
               wr_entry.valid      = 1'b1;
               wr_entry.device_id  = cmd_ff.device_id;
               wr_entry.start_time = cmd_ff.timestamp_ns;
            end else if (found_ff) begin
               // free the slot and take the modular difference
               wr_en    = 1'b1;
               wr_addr  = match_idx_ff;
               diff_in  = cmd_ff.timestamp_ns - match_time_ff;
               state_in = ST_BUCKET;
            end
         end
         ST_BUCKET: begin
            counts_in[bucket] = counts_ff[bucket] + CNT_W'(1);
            state_in          = ST_IDLE;
         end
         ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = rd_k_ff;
               rsp_count_in = counts_ff[rd_k_ff];
               rsp_last_in  = (rd_k_ff == ilh_pkg::LAST_BUCKET);
               if (rd_k_ff == ilh_pkg::LAST_BUCKET) begin
                  rd_k_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  rd_k_in = rd_k_ff + BKT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rd_idx_ff    <= '0;
         iss_done_ff  <= 1'b0;
         rd_pend_ff   <= 1'b0;
         found_ff     <= 1'b0;
         free_ok_ff   <= 1'b0;
         rd_k_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < ilh_pkg::NUM_BUCKETS; i++) begin
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         iss_done_ff  <= iss_done_in;
         rd_pend_ff   <= rd_pend_in;
         found_ff     <= found_in;
         free_ok_ff   <= free_ok_in;
         rd_k_ff      <= rd_k_in;
         rsp_valid_ff <= rsp_valid_in;
         counts_ff    <= counts_in;
      end
      cmd_ff        <= cmd_in;
      cmp_idx_ff    <= cmp_idx_in;
      match_idx_ff  <= match_idx_in;
      match_time_ff <= match_time_in;
      free_idx_ff   <= free_idx_in;
      diff_ff       <= diff_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.bucket_index = rsp_index_ff;
   assign rsp_ch.bucket_count = rsp_count_ff;
   assign rsp_ch.last         = rsp_last_ff;
endmodule

// ===== hw/rtl/io_latency_histogram_top.sv =====
// io latency histogram: per-device request latency in eight log-spaced buckets
// depends on ilh_pkg, ilh_req_if, ilh_rsp_if, ilh_front, ilh_queue, ilh_back, io_latency_histogram_top_defines.svh
//
// req_ch carries one event per beat: func issue stores the device's start
// time in a table of TABLE_ENTRIES slots, complete looks the device up, bins
// the elapsed time (in units of NS_PER_UNIT ns) and frees the slot, readout
// sends all eight counts on rsp_ch, bucket 0 first, last set on the eighth.
// issue and complete give no response beat; func code 3 is taken and dropped.
// the front end holds one decoded beat and feeds a two-deep command queue,
// so a few events are taken while the back end works or rsp_ch stalls.
// the back end scans the table memory one slot a cycle through its single
// read port, then a decide step writes the issue entry or frees the slot of
// a complete, and a bucket step counts it (skipped for an absent device);
// readout beats are registered, the first once the state has moved to readout.
// after reset the table is swept clear slot by slot, req_ch.ready stays low
// during the sweep; histogram counts are cleared by reset at once.
// a stalled rsp_ch holds its beat and the readout waits for it, while the
// front end goes on filling the queue.
module io_latency_histogram_top #(
   parameter int unsigned TABLE_ENTRIES = 16,
   parameter int unsigned NS_PER_UNIT   = 1000
) (
   input  logic         clock,
   input  logic         reset,
   ilh_req_if.sink      req_ch,
   ilh_rsp_if.source    rsp_ch
);
   `include "io_latency_histogram_top_defines.svh"

   // front to queue
   logic                      q_push;
   ilh_pkg::cmd_type          q_push_data;
   logic                      q_full;
   // queue to back end
   logic                      q_pop;
   ilh_pkg::cmd_type          q_pop_data;
   logic                      q_empty;
   ilh_pkg::back_status_type  back_status;

   ilh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .hold_off  (back_status.clearing),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full)
   );

   ilh_queue #(
      .DEPTH (2)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   ilh_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .NS_PER_UNIT   (NS_PER_UNIT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .pop      (q_pop),
      .pop_data (q_pop_data),
      .empty    (q_empty),
      .rsp_ch   (rsp_ch),
      .status   (back_status)
   );

   // no request beat taken while the table sweep runs
   `ILH_ASSERT_IMPLY(a_no_accept_in_clear, clock, reset, req_ch.valid && req_ch.ready, !back_status.clearing, "request taken during table sweep")
   // queue never written when full
   `ILH_ASSERT_IMPLY(a_queue_no_overflow, clock, reset, q_push, !q_full, "push into full queue")
   // the last readout beat carries the top bucket
   `ILH_ASSERT_IMPLY(a_last_is_top, clock, reset, rsp_ch.valid && rsp_ch.last, rsp_ch.bucket_index == ilh_pkg::LAST_BUCKET, "last beat not on top bucket")
   // the sweep runs only once after reset
   `ILH_ASSERT_NEXT(a_clear_once, clock, reset, !back_status.clearing, !back_status.clearing, "table sweep restarted")
   // commands leave the queue only while the back end is idle
   `ILH_ASSERT_IMPLY(a_pop_when_idle, clock, reset, q_pop, !back_status.busy, "pop while busy")
endmodule
